>>> rtl/pose_history_weighted_filter_core_macros.svh
// Assertion helpers for the pose history filter.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef POSE_HISTORY_WEIGHTED_FILTER_CORE_MACROS_SVH
`define POSE_HISTORY_WEIGHTED_FILTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PHWF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phwf assertion failed");
`define PHWF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phwf assertion failed");
`else
`define PHWF_ASSERT_IMP(label, ante, cons)
`define PHWF_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/phwf_pkg.sv
package phwf_pkg;

    // History geometry
    localparam int HISTORY_DEPTH = 8;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    // Weight and accumulator widths
    localparam int COEF_W = $clog2(5 * (HISTORY_DEPTH - 1) + 1);
    localparam int WGT_W  = 16 + COEF_W;
    localparam int WSUM_W = WGT_W + $clog2(HISTORY_DEPTH + 1);
    localparam int TRIG_W = 18;
    localparam int PROD_W = WGT_W + TRIG_W;
    localparam int ACC_W  = PROD_W + $clog2(HISTORY_DEPTH + 1);
    localparam int FLR_W  = WSUM_W + 8;

    // CORDIC
    localparam int CORD_W     = ACC_W + 2;
    localparam int ANG_W      = 34;
    localparam int CORD_STEPS = 20;
    localparam int STEP_W     = $clog2(CORD_STEPS);
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);

    // Divider
    localparam int QUO_W = 17;
    localparam int NUM_W = ACC_W + 1;
    localparam int DEN_W = WSUM_W + 1;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FLOOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GATE = 1'd1;
    localparam logic [CFG_W-1:0] WEIGHT_FLOOR_RST = 16'd66;
    localparam logic [CFG_W-1:0] HEADING_GATE_RST = 16'd2731;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        heading_in;
        logic [15:0]        confidence;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [15:0]        heading_out;
        logic               was_filtered;
        logic               heading_replaced;
    } result_t;

    // One history entry: heading kept as its cosine and sine
    typedef struct packed {
        logic signed [15:0]       x;
        logic signed [15:0]       y;
        logic signed [15:0]       z;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
        logic [15:0]              conf;
    } entry_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_sts_t;

    // atan(2^-k) in 2^32 units per turn
    function automatic logic [29:0] atan_unit(input logic [STEP_W-1:0] k);
        logic [29:0] r;
        case (k)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // Ring index wrap for a sum below twice the depth
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] s);
        logic [CNT_W:0] r;
        if (s >= (CNT_W+1)'(HISTORY_DEPTH))
            r = s - (CNT_W+1)'(HISTORY_DEPTH);
        else
            r = s;
        return r[SLOT_W-1:0];
    endfunction

endpackage

>>> rtl/phwf_sample_if.sv
interface phwf_sample_if;
    import phwf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/phwf_result_if.sv
interface phwf_result_if;
    import phwf_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/phwf_ram.sv
module phwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

>>> rtl/phwf_cordic.sv
module phwf_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  phwf_pkg::cordic_cmd_t              cmd,
    input  logic [31:0]                        angle,
    input  logic signed [phwf_pkg::CORD_W-1:0] vec_x,
    input  logic signed [phwf_pkg::CORD_W-1:0] vec_y,
    output phwf_pkg::cordic_sts_t              sts,
    output logic signed [phwf_pkg::CORD_W-1:0] x_res,
    output logic signed [phwf_pkg::CORD_W-1:0] y_res,
    output logic [31:0]                        ang_res
);
    import phwf_pkg::*;

    logic signed [CORD_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic [STEP_W-1:0]        k_reg;
    logic                     busy_reg, done_reg, vect_reg, flip_reg;

    logic signed [CORD_W-1:0] dx, dy, x_step, y_step;
    logic signed [ANG_W-1:0]  at, z_step;
    logic                     sub_x;
    logic [31:0]              a_half, a_turn;
    logic                     a_flip;

    // one micro-rotation per cycle
    always_comb
    begin
        dx    = y_reg >>> k_reg;
        dy    = x_reg >>> k_reg;
        at    = $signed({4'b0, atan_unit(k_reg)});
        sub_x = vect_reg ? !(y_reg > 0) : !z_reg[ANG_W-1];
        if (sub_x)
        begin
            x_step = x_reg - dx;
            y_step = y_reg + dy;
            z_step = z_reg - at;
        end
        else
        begin
            x_step = x_reg + dx;
            y_step = y_reg - dy;
            z_step = z_reg + at;
        end
    end

    // rotation start: fold the left half plane by a half turn
    always_comb
    begin
        a_half = angle + 32'h4000_0000;
        a_flip = a_half[31];
        a_turn = a_flip ? angle + 32'h8000_0000 : angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
            vect_reg <= 1'b0;
            flip_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
                vect_reg <= cmd.vectoring;
                if (cmd.vectoring)
                begin
                    flip_reg <= 1'b0;
                    if (vec_x < 0)
                    begin
                        x_reg <= -vec_x;
                        y_reg <= -vec_y;
                        z_reg <= ANG_W'(34'h0_8000_0000);
                    end
                    else
                    begin
                        x_reg <= vec_x;
                        y_reg <= vec_y;
                        z_reg <= '0;
                    end
                end
                else
                begin
                    flip_reg <= a_flip;
                    x_reg    <= CORDIC_GAIN;
                    y_reg    <= '0;
                    z_reg    <= $signed({{(ANG_W-32){a_turn[31]}}, a_turn});
                end
            end
            else if (busy_reg)
            begin
                z_reg <= z_step;
                if (k_reg == STEP_W'(CORD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    x_reg    <= flip_reg ? -x_step : x_step;
                    y_reg    <= flip_reg ? -y_step : y_step;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                    x_reg <= x_step;
                    y_reg <= y_step;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign x_res    = x_reg;
    assign y_res    = y_reg;
    assign ang_res  = z_reg[31:0];
endmodule

>>> rtl/phwf_div.sv
module phwf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [phwf_pkg::NUM_W-1:0]   num,
    input  logic [phwf_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [phwf_pkg::QUO_W-1:0]   quo
);
    import phwf_pkg::*;

    localparam int QCNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [QUO_W-1:0]  low_reg, quo_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    // restoring step: quotient is known to fit QUO_W bits
    always_comb
    begin
        trial = {rem_reg, low_reg[QUO_W-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= DEN_W'(num[NUM_W-1:QUO_W]);
                low_reg  <= num[QUO_W-1:0];
                den_reg  <= den;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                if (cnt_reg == QCNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

>>> rtl/pose_history_weighted_filter_core.sv
// Pose history filter.
// sample: one pose request (x, y, z, heading, confidence), taken when
//   valid and ready are high; ready is high only while the core is idle.
// result: one result per sample, held in an output register until taken.
//   A new sample may be accepted while the previous result still waits.
// cfg_we / cfg_index / cfg_data: register writes, only while idle.
//   Index 0 is weight_floor, index 1 heading_gate.
// Sequence after accept: the shared CORDIC gives the new heading's
//   sine/cosine (20 iterations); with fewer than three entries held the
//   sample then goes to the output unfiltered. Else each history entry is
//   walked through the product multiplier (read, weight, then the x, y, z,
//   cosine and sine products); if the weight sum is above the floor, three
//   17-step divisions follow and, unless the sine and cosine sums are both
//   zero, a CORDIC atan2 (20 iterations).
// Reset clears the fill count, the ring pointer and the output valid; the
//   history memory is not cleared, only written entries are ever read.
// When the receiver stalls the result register holds; a finished second
//   result waits in the output state and no further sample is taken.
`include "pose_history_weighted_filter_core_macros.svh"

module pose_history_weighted_filter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    phwf_sample_if.sink                       sample,
    phwf_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [phwf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phwf_pkg::CFG_W-1:0]        cfg_data
);
    import phwf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SINCOS, S_ACC, S_CHECK, S_DIV, S_ATAN, S_GATE, S_OUT
    } state_t;

    localparam logic [2:0] SEL_X = 3'd0;
    localparam logic [2:0] SEL_Y = 3'd1;
    localparam logic [2:0] SEL_Z = 3'd2;
    localparam logic [2:0] SEL_C = 3'd3;
    localparam logic [2:0] SEL_S = 3'd4;

    state_t state_reg;

    logic [CFG_W-1:0]  weight_floor_reg, heading_gate_reg;
    sample_t           sample_reg;
    logic [SLOT_W-1:0] slot_reg, oldest_reg;
    logic [CNT_W-1:0]  fill_reg, n_reg, idx_reg;
    logic [2:0]        ph_reg;

    logic [WGT_W-1:0]         w_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic [2:0]               prod_sel_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg, acc_z_reg, acc_c_reg, acc_s_reg;
    logic [WSUM_W-1:0]        wsum_reg;

    logic [1:0]  div_idx_reg;
    logic [15:0] mean_x_reg, mean_y_reg, mean_z_reg, fh_reg;
    logic        filt_reg, repl_reg;
    result_t     res_reg;
    logic        res_valid_reg;

    // handshake
    logic accept;
    logic out_load;
    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;
    assign out_load     = (state_reg == S_OUT) && (!res_valid_reg || result.ready);

    // ring slot for the incoming sample
    logic [SLOT_W-1:0] new_slot;
    logic              ring_full;
    always_comb
    begin
        ring_full = (fill_reg == CNT_W'(HISTORY_DEPTH));
        new_slot  = ring_full ? oldest_reg
                              : wrap_slot({1'b0, oldest_reg} + (CNT_W+1)'(fill_reg));
    end

    // history memory
    entry_t            ram_wdata, ram_rdata;
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_raddr;

    // shared CORDIC
    cordic_cmd_t              cord_cmd;
    cordic_sts_t              cord_sts;
    logic signed [CORD_W-1:0] cord_x, cord_y;
    logic [31:0]              cord_ang;
    logic signed [CORD_W-1:0] cos_full, sin_full;

    // divider
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [QUO_W-1:0]  div_quo;
    logic [1:0]        div_sel;
    logic signed [ACC_W-1:0] div_acc;
    logic [ACC_W-1:0]  div_mag;
    logic              atan_go, sums_zero, floor_pass, last_div;

    phwf_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    phwf_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cord_cmd),
        .angle   ({sample.data.heading_in, 16'h0000}),
        .vec_x   (CORD_W'(acc_c_reg)),
        .vec_y   (CORD_W'(acc_s_reg)),
        .sts     (cord_sts),
        .x_res   (cord_x),
        .y_res   (cord_y),
        .ang_res (cord_ang)
    );

    phwf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // new entry: Q15 cosine and sine of the sample heading
    always_comb
    begin
        cos_full        = (cord_x + CORD_W'(16384)) >>> 15;
        sin_full        = (cord_y + CORD_W'(16384)) >>> 15;
        ram_wdata.x     = sample_reg.pos_x;
        ram_wdata.y     = sample_reg.pos_y;
        ram_wdata.z     = sample_reg.pos_z;
        ram_wdata.cos_v = cos_full[TRIG_W-1:0];
        ram_wdata.sin_v = sin_full[TRIG_W-1:0];
        ram_wdata.conf  = sample_reg.confidence;
        ram_we          = (state_reg == S_SINCOS) && cord_sts.done;
        ram_re          = (state_reg == S_ACC) && (ph_reg == 3'd0);
        ram_raddr       = wrap_slot({1'b0, oldest_reg} + (CNT_W+1)'(idx_reg));
    end

    // weight and products
    logic [COEF_W-1:0]        coef;
    logic signed [TRIG_W-1:0] mult_b;
    logic signed [WGT_W+TRIG_W:0] mult_p;
    always_comb
    begin
        coef = COEF_W'((n_reg - 1'b1) * 3 + idx_reg * 2);
        case (ph_reg)
            3'd2:    mult_b = TRIG_W'(ram_rdata.x);
            3'd3:    mult_b = TRIG_W'(ram_rdata.y);
            3'd4:    mult_b = TRIG_W'(ram_rdata.z);
            3'd5:    mult_b = ram_rdata.cos_v;
            default: mult_b = ram_rdata.sin_v;
        endcase
        mult_p = $signed({1'b0, w_reg}) * mult_b;
    end

    // floor test: sum * 256 > floor * 5 * (n - 1)
    always_comb
    begin
        floor_pass = {wsum_reg, 8'h00} >
                     FLR_W'(weight_floor_reg) * FLR_W'(COEF_W'((n_reg - 1'b1) * 5));
        sums_zero  = (acc_c_reg == '0) && (acc_s_reg == '0);
        last_div   = (div_idx_reg == 2'd2);
    end

    // divider operands: round half away from zero
    always_comb
    begin
        div_sel = (state_reg == S_CHECK) ? 2'd0 : div_idx_reg + 1'b1;
        case (div_sel)
            2'd0:    div_acc = acc_x_reg;
            2'd1:    div_acc = acc_y_reg;
            default: div_acc = acc_z_reg;
        endcase
        div_mag   = div_acc[ACC_W-1] ? ACC_W'(-div_acc) : ACC_W'(div_acc);
        div_num   = {div_mag, 1'b0} + NUM_W'(wsum_reg);
        div_den   = {wsum_reg, 1'b0};
        div_start = ((state_reg == S_CHECK) && floor_pass) ||
                    ((state_reg == S_DIV) && div_done && !last_div);
    end

    // signed mean of the division just finished
    logic signed [ACC_W-1:0] fin_acc;
    logic [QUO_W-1:0]        fin_q;
    always_comb
    begin
        case (div_idx_reg)
            2'd0:    fin_acc = acc_x_reg;
            2'd1:    fin_acc = acc_y_reg;
            default: fin_acc = acc_z_reg;
        endcase
        fin_q = fin_acc[ACC_W-1] ? QUO_W'(-div_quo) : div_quo;
    end

    // CORDIC requests
    always_comb
    begin
        atan_go            = (state_reg == S_DIV) && div_done && last_div && !sums_zero;
        cord_cmd.start     = accept || atan_go;
        cord_cmd.vectoring = atan_go;
    end

    // heading gate
    logic [31:0] ang_round;
    logic [15:0] hdiff;
    logic [16:0] hdist;
    always_comb
    begin
        ang_round = cord_ang + 32'h0000_8000;
        hdiff     = fh_reg - sample_reg.heading_in;
        hdist     = (hdiff > 16'h8000) ? 17'h1_0000 - {1'b0, hdiff} : {1'b0, hdiff};
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_floor_reg <= WEIGHT_FLOOR_RST;
            heading_gate_reg <= HEADING_GATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WEIGHT_FLOOR: weight_floor_reg <= cfg_data;
                CFG_HEADING_GATE: heading_gate_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            res_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            ph_reg         <= '0;
            idx_reg        <= '0;
            div_idx_reg    <= '0;
            filt_reg       <= 1'b0;
            repl_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= 1'b0;
            // a new result replaces one taken in the same cycle
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                res_valid_reg <= 1'b0;

            // accumulate the product of the previous cycle
            if (prod_valid_reg)
            begin
                case (prod_sel_reg)
                    SEL_X:   acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
                    SEL_Y:   acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
                    SEL_Z:   acc_z_reg <= acc_z_reg + ACC_W'(prod_reg);
                    SEL_C:   acc_c_reg <= acc_c_reg + ACC_W'(prod_reg);
                    default: acc_s_reg <= acc_s_reg + ACC_W'(prod_reg);
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= sample.data;
                        slot_reg   <= new_slot;
                        filt_reg   <= 1'b0;
                        repl_reg   <= 1'b0;
                        if (ring_full)
                        begin
                            oldest_reg <= wrap_slot({1'b0, oldest_reg} + (CNT_W+1)'(1));
                            n_reg      <= fill_reg;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            n_reg    <= fill_reg + 1'b1;
                        end
                        state_reg <= S_SINCOS;
                    end
                end
                S_SINCOS:
                begin
                    if (cord_sts.done)
                    begin
                        acc_x_reg <= '0;
                        acc_y_reg <= '0;
                        acc_z_reg <= '0;
                        acc_c_reg <= '0;
                        acc_s_reg <= '0;
                        wsum_reg  <= '0;
                        idx_reg   <= '0;
                        ph_reg    <= '0;
                        state_reg <= (n_reg < CNT_W'(3)) ? S_OUT : S_ACC;
                    end
                end
                S_ACC:
                begin
                    case (ph_reg)
                        3'd0: ph_reg <= 3'd1;
                        3'd1:
                        begin
                            w_reg  <= WGT_W'(ram_rdata.conf) * WGT_W'(coef);
                            ph_reg <= 3'd2;
                        end
                        default:
                        begin
                            prod_reg       <= PROD_W'(mult_p);
                            prod_valid_reg <= 1'b1;
                            prod_sel_reg   <= ph_reg - 3'd2;
                            if (ph_reg == 3'd2)
                                wsum_reg <= wsum_reg + WSUM_W'(w_reg);
                            if (ph_reg == 3'd6)
                            begin
                                ph_reg <= 3'd0;
                                if (idx_reg == n_reg - 1'b1)
                                    state_reg <= S_CHECK;
                                else
                                    idx_reg <= idx_reg + 1'b1;
                            end
                            else
                                ph_reg <= ph_reg + 1'b1;
                        end
                    endcase
                end
                S_CHECK:
                begin
                    div_idx_reg <= 2'd0;
                    if (floor_pass)
                    begin
                        filt_reg  <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        case (div_idx_reg)
                            2'd0:    mean_x_reg <= fin_q[15:0];
                            2'd1:    mean_y_reg <= fin_q[15:0];
                            default: mean_z_reg <= fin_q[15:0];
                        endcase
                        if (last_div)
                        begin
                            if (sums_zero)
                            begin
                                fh_reg    <= 16'h0000;
                                state_reg <= S_GATE;
                            end
                            else
                                state_reg <= S_ATAN;
                        end
                        else
                            div_idx_reg <= div_idx_reg + 1'b1;
                    end
                end
                S_ATAN:
                begin
                    if (cord_sts.done)
                    begin
                        fh_reg    <= ang_round[31:16];
                        state_reg <= S_GATE;
                    end
                end
                S_GATE:
                begin
                    if (hdist < {1'b0, heading_gate_reg})
                        repl_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        res_reg.out_x            <= filt_reg ? mean_x_reg : sample_reg.pos_x;
                        res_reg.out_y            <= filt_reg ? mean_y_reg : sample_reg.pos_y;
                        res_reg.out_z            <= filt_reg ? mean_z_reg : sample_reg.pos_z;
                        res_reg.heading_out      <= repl_reg ? fh_reg : sample_reg.heading_in;
                        res_reg.was_filtered     <= filt_reg;
                        res_reg.heading_replaced <= repl_reg;
                        state_reg                <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `PHWF_ASSERT_IMP(a_fill_range, 1'b1, fill_reg <= CNT_W'(HISTORY_DEPTH))
    `PHWF_ASSERT_NXT(a_accept_starts, accept, state_reg == S_SINCOS && cord_sts.busy)
    `PHWF_ASSERT_IMP(a_ram_port_excl, ram_re, !ram_we)
    `PHWF_ASSERT_IMP(a_repl_needs_filt, res_valid_reg && res_reg.heading_replaced, res_reg.was_filtered)
endmodule

>>> tb/pose_history_weighted_filter_core_tb.sv
`timescale 1ns / 100ps

module pose_history_weighted_filter_core_tb;
    import phwf_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 300;
    localparam int FIFO_DEPTH = 1024;

    localparam longint ATAN_TAB [20] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    phwf_sample_if sample_ch ();
    phwf_result_if result_ch ();

    pose_history_weighted_filter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch.sink),
        .result    (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: pose ring and register copies
    sample_t ring [DEPTH];
    int ring_count;
    int ring_oldest;
    logic [15:0] floor_reg;
    logic [15:0] gate_reg;

    // Expected results in request order
    result_t want_fifo [FIFO_DEPTH];
    int want_wr;
    int want_rd;
    int mismatches;
    int requests_sent;
    int results_seen;
    int filtered_seen;
    int replaced_seen;
    int send_idle_pct;
    int take_idle_pct;
    int idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    // CORDIC rotation giving Q15 cosine and sine of a binary angle
    function automatic void heading_trig(logic [15:0] h, output longint c, output longint s);
        logic [31:0] a;
        bit flip;
        longint x, y, z, dx, dy;
        a = {h, 16'h0};
        flip = 0;
        x = 652032874;
        y = 0;
        if (((a + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            a = a + 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(a));
        for (int k = 0; k < 20; k++)
        begin
            dx = floor_shr(y, k);
            dy = floor_shr(x, k);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TAB[k];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TAB[k];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = floor_shr(x + 16384, 15);
        s = floor_shr(y + 16384, 15);
    endfunction

    // CORDIC vectoring for the mean heading
    function automatic logic [15:0] mean_heading(longint x, longint y);
        logic [31:0] ang;
        longint dx, dy;
        logic [31:0] r;
        ang = 0;
        if (x == 0 && y == 0)
            return 16'h0;
        if (x < 0)
        begin
            x = -x; y = -y; ang = 32'h8000_0000;
        end
        for (int k = 0; k < 20; k++)
        begin
            dx = floor_shr(y, k);
            dy = floor_shr(x, k);
            if (y > 0)
            begin
                x += dx; y -= dy; ang = ang + 32'(ATAN_TAB[k]);
            end
            else
            begin
                x -= dx; y += dy; ang = ang - 32'(ATAN_TAB[k]);
            end
        end
        r = (ang + 32'h8000) >> 16;
        return r[15:0];
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    // Push a pose into the ring and predict the filtered result
    function automatic result_t filter_pose(sample_t p);
        result_t r;
        int slot, n, e;
        longint w, c, s, sx, sy, sz, ss, sc, wsum;
        logic [15:0] fh, d;
        sx = 0; sy = 0; sz = 0; ss = 0; sc = 0; wsum = 0;
        if (ring_count < DEPTH)
        begin
            slot = (ring_oldest + ring_count) % DEPTH;
            ring_count++;
        end
        else
        begin
            slot = ring_oldest;
            ring_oldest = (slot + 1) % DEPTH;
        end
        ring[slot] = p;
        r.out_x = p.pos_x;
        r.out_y = p.pos_y;
        r.out_z = p.pos_z;
        r.heading_out = p.heading_in;
        r.was_filtered = 1'b0;
        r.heading_replaced = 1'b0;
        n = ring_count;
        if (n >= 3)
        begin
            for (int i = 0; i < n; i++)
            begin
                e = (ring_oldest + i) % DEPTH;
                w = longint'(ring[e].confidence) * (3 * (n - 1) + 2 * i);
                sx += w * ring[e].pos_x;
                sy += w * ring[e].pos_y;
                sz += w * ring[e].pos_z;
                heading_trig(ring[e].heading_in, c, s);
                sc += w * c;
                ss += w * s;
                wsum += w;
            end
            if (wsum * 256 > longint'(floor_reg) * 5 * (n - 1))
            begin
                r.was_filtered = 1'b1;
                r.out_x = 16'(round_div(sx, wsum));
                r.out_y = 16'(round_div(sy, wsum));
                r.out_z = 16'(round_div(sz, wsum));
                fh = mean_heading(sc, ss);
                d = fh - p.heading_in;
                if ({1'b0, d} > 17'd32768)
                    d = 16'(17'd65536 - d);
                if ({1'b0, d} < {1'b0, gate_reg} || (d == 16'h8000 && gate_reg > 16'h8000))
                begin
                    r.heading_out = fh;
                    r.heading_replaced = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch on result %0d: %s got %0d want %0d",
                 results_seen, what, got, want);
    endtask

    task automatic send_pose(sample_t p);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.data <= p;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        want_fifo[want_wr % FIFO_DEPTH] = filter_pose(p);
        want_wr++;
        requests_sent++;
        sample_ch.valid <= 1'b0;
        // the core is busy after accepting a request
        @(posedge clk);
    endtask

    // Registers change only when the core is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        while (want_wr != want_rd)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WEIGHT_FLOOR)
            floor_reg = val;
        else
            gate_reg = val;
    endtask

    function automatic sample_t random_pose();
        sample_t p;
        p.pos_x = 16'($urandom);
        p.pos_y = 16'($urandom);
        p.pos_z = 16'($urandom);
        p.heading_in = 16'($urandom);
        case ($urandom_range(3))
            0: p.confidence = 16'($urandom_range(0, 3));
            1: p.confidence = 16'hFFFF - 16'($urandom_range(0, 3));
            default: p.confidence = 16'($urandom);
        endcase
        return p;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (want_wr == want_rd)
                    report_mismatch("result with nothing outstanding", 1, 0);
                else
                begin
                    want = want_fifo[want_rd % FIFO_DEPTH];
                    want_rd++;
                    if (result_ch.data.out_x !== want.out_x)
                        report_mismatch("out_x", result_ch.data.out_x, want.out_x);
                    if (result_ch.data.out_y !== want.out_y)
                        report_mismatch("out_y", result_ch.data.out_y, want.out_y);
                    if (result_ch.data.out_z !== want.out_z)
                        report_mismatch("out_z", result_ch.data.out_z, want.out_z);
                    if (result_ch.data.heading_out !== want.heading_out)
                        report_mismatch("heading_out", result_ch.data.heading_out,
                                        want.heading_out);
                    if (result_ch.data.was_filtered !== want.was_filtered)
                        report_mismatch("was_filtered", result_ch.data.was_filtered,
                                        want.was_filtered);
                    if (result_ch.data.heading_replaced !== want.heading_replaced)
                        report_mismatch("heading_replaced", result_ch.data.heading_replaced,
                                        want.heading_replaced);
                    filtered_seen += want.was_filtered;
                    replaced_seen += want.heading_replaced;
                end
                results_seen++;
            end
            result_ch.ready <= !(take_idle_pct > 0 && $urandom_range(99) < take_idle_pct);
        end
    end

    // Watchdog on stalled traffic
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Fields at their extremes over a short history, then floor, cancelling headings and ring wrap
    task automatic test_extremes();
        sample_t p;
        p = '{16'sh7FFF, -16'sd32768, 16'sd0, 16'h0000, 16'h0000};
        send_pose(p);
        p = '{-16'sd32768, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF};
        send_pose(p);
        p = '{-16'sd32768, -16'sd32768, -16'sd32768, 16'h8000, 16'hFFFF};
        send_pose(p);
        p = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h4000, 16'hFFFF};
        send_pose(p);
        p = '{16'sd1, -16'sd1, 16'sd0, 16'hC000, 16'h0001};
        send_pose(p);
        // zero confidence: weight sum falls below the floor
        for (int i = 0; i < 8; i++)
        begin
            p = '{16'(i), 16'(-i), 16'sd5, 16'(i * 8192), 16'h0000};
            send_pose(p);
        end
        // opposed headings with equal weights on the oldest and newest entry:
        // trig sums cancel to zero once the ring holds these eight
        for (int i = 0; i < 8; i++)
        begin
            p = '{16'sd100, 16'sd200, -16'sd300, (i % 2) ? 16'h8000 : 16'h0000,
                  (i == 0) ? 16'd35 : ((i == 7) ? 16'd21 : 16'd0)};
            send_pose(p);
        end
        // ring wrap with steady headings, gate accepts
        for (int i = 0; i < 6; i++)
        begin
            p = '{16'(i * 1000), 16'sd7, -16'sd7, 16'h1234 + 16'(i), 16'h0100 + 16'(i)};
            send_pose(p);
        end
    endtask

    task automatic test_random(int count);
        sample_t p;
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < count; i++)
        begin
            p = random_pose();
            // mostly clustered headings so the gate decides both ways
            if ($urandom_range(3) != 0)
                p.heading_in = base + 16'($urandom_range(0, 4000)) - 16'd2000;
            if ($urandom_range(15) == 0)
                base = 16'($urandom);
            send_pose(p);
        end
    endtask

    task automatic test_settings();
        write_reg(CFG_WEIGHT_FLOOR, 16'd0);
        write_reg(CFG_HEADING_GATE, 16'd0);
        test_random(60);
        write_reg(CFG_WEIGHT_FLOOR, 16'hFFFF);
        write_reg(CFG_HEADING_GATE, 16'hFFFF);
        test_random(60);
        write_reg(CFG_HEADING_GATE, 16'h8000);
        write_reg(CFG_WEIGHT_FLOOR, 16'd5000);
        test_random(60);
        write_reg(CFG_HEADING_GATE, 16'h8001);
        write_reg(CFG_WEIGHT_FLOOR, 16'd66);
        test_random(60);
        write_reg(CFG_HEADING_GATE, 16'd2731);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        result_ch.ready = 1'b0;
        ring_count = 0;
        ring_oldest = 0;
        floor_reg = WEIGHT_FLOOR_RST;
        gate_reg = HEADING_GATE_RST;
        want_wr = 0;
        want_rd = 0;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        filtered_seen = 0;
        replaced_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 31;
        take_idle_pct = 57;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_random(200);
        send_idle_pct = 57;
        take_idle_pct = 31;
        test_settings();
        send_idle_pct = 0;
        take_idle_pct = 0;
        test_random(430);

        while (want_wr != want_rd)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("%0d pose requests, %0d results: %0d filtered, %0d heading replaced",
                 requests_sent, results_seen, filtered_seen, replaced_seen);
        $display("register extremes and three idling mixes covered");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/phwf_pkg.sv
rtl/phwf_sample_if.sv
rtl/phwf_result_if.sv
rtl/phwf_ram.sv
rtl/phwf_cordic.sv
rtl/phwf_div.sv
rtl/pose_history_weighted_filter_core.sv
tb/pose_history_weighted_filter_core_tb.sv
